FILE: rtl/core/ilds_pkg.sv
package ilds_pkg;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_LEAD   = 2'd1,
      PH_PREFIX = 2'd2,
      PH_DIGITS = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      BASE_INVALID = 3'd0,
      BASE_BIN     = 3'd1,
      BASE_OCT     = 3'd2,
      BASE_DEC     = 3'd3,
      BASE_HEX     = 3'd4
   } base_type;

   typedef enum logic [1:0] {
      SEP_NONE  = 2'd0,
      SEP_APOS  = 2'd1,
      SEP_UNDER = 2'd2
   } sep_type;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_O = 8'h6F;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CASE_GAP   = 8'h20;
   localparam logic [7:0] HEX_OFFSET = CH_LOWER_A - 8'd10;
   localparam logic [4:0] NO_DIGIT   = 5'd16;

   typedef struct packed {
      phase_type  phase;
      base_type   base;
      logic       neg;
      logic       err;
      sep_type    sep_lock;
      logic       sep_pending;
   } state_type;

   typedef struct packed {
      logic [3:0] digit_value;
      logic       digit_strobe;
      base_type   base;
      logic       negative;
      logic       error;
      logic       finished;
   } result_type;

   localparam state_type STATE_CLEAR = '{
      phase: PH_START, base: BASE_INVALID, neg: 1'b0, err: 1'b0,
      sep_lock: SEP_NONE, sep_pending: 1'b0};

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return c + CASE_GAP;
      end
      return c;
   endfunction

   function automatic logic [4:0] radix_of(input base_type b);
      unique case (b)
         BASE_BIN: return 5'd2;
         BASE_OCT: return 5'd8;
         BASE_DEC: return 5'd10;
         BASE_HEX: return 5'd16;
         default:  return 5'd0;
      endcase
   endfunction

endpackage

FILE: rtl/core/ilds_step.sv
module ilds_step (
   input  ilds_pkg::state_type  state_cur,
   input  logic [7:0]           ch,
   input  logic                 first,
   input  logic                 last,
   output ilds_pkg::state_type  state_next,
   output ilds_pkg::result_type result
);

   always_comb begin
      ilds_pkg::state_type st;
      ilds_pkg::sep_type   kind;
      logic                consumed;
      logic                is_sep;
      logic                strobe;
      logic [3:0]          value;
      logic [7:0]          lc;
      logic [7:0]          diff;
      logic [4:0]          d;

      st       = state_cur;
      consumed = 1'b0;
      is_sep   = 1'b0;
      strobe   = 1'b0;
      value    = 4'd0;
      lc       = ilds_pkg::to_lower(ch);
      diff     = 8'd0;
      d        = ilds_pkg::NO_DIGIT;
      kind     = ilds_pkg::SEP_NONE;

      if (first || state_cur.phase == ilds_pkg::PH_START) begin
         st       = ilds_pkg::STATE_CLEAR;
         st.phase = ilds_pkg::PH_LEAD;
         if (ch == ilds_pkg::CH_MINUS || ch == ilds_pkg::CH_PLUS) begin
            st.neg   = (ch == ilds_pkg::CH_MINUS);
            st.err   = last;   // lone sign
            consumed = 1'b1;
         end
      end

      if (!consumed) begin
         unique case (st.phase)
            ilds_pkg::PH_LEAD: begin
               if (ch == ilds_pkg::CH_ZERO && !last) begin
                  st.phase = ilds_pkg::PH_PREFIX;
               end else if (ch >= ilds_pkg::CH_ZERO && ch <= ilds_pkg::CH_NINE) begin
                  diff     = ch - ilds_pkg::CH_ZERO;
                  st.base  = ilds_pkg::BASE_DEC;
                  strobe   = 1'b1;
                  value    = diff[3:0];
                  st.phase = ilds_pkg::PH_DIGITS;
               end else begin
                  st.err   = 1'b1;
                  st.phase = ilds_pkg::PH_DIGITS;
               end
            end
            ilds_pkg::PH_PREFIX: begin
               priority if (lc == ilds_pkg::CH_LOWER_B) begin
                  st.base = ilds_pkg::BASE_BIN;
               end else if (lc == ilds_pkg::CH_LOWER_O) begin
                  st.base = ilds_pkg::BASE_OCT;
               end else if (lc == ilds_pkg::CH_LOWER_X) begin
                  st.base = ilds_pkg::BASE_HEX;
               end else begin
                  st.base = ilds_pkg::BASE_INVALID;
               end
               st.phase = ilds_pkg::PH_DIGITS;
            end
            default: begin
               if (!st.err) begin
                  if (ch == ilds_pkg::CH_APOS) begin
                     kind = ilds_pkg::SEP_APOS;
                  end else if (ch == ilds_pkg::CH_UNDER) begin
                     kind = ilds_pkg::SEP_UNDER;
                  end
                  // first separator seen locks the kind for the literal
                  if (kind != ilds_pkg::SEP_NONE && !st.sep_pending) begin
                     if (st.sep_lock == ilds_pkg::SEP_NONE) begin
                        st.sep_lock = kind;
                        is_sep      = 1'b1;
                     end else if (st.sep_lock == kind) begin
                        is_sep = 1'b1;
                     end
                  end
                  if (is_sep) begin
                     st.sep_pending = 1'b1;
                     if (last) begin
                        st.err = 1'b1;
                     end
                  end else begin
                     st.sep_pending = 1'b0;
                     if (lc >= ilds_pkg::CH_ZERO && lc <= ilds_pkg::CH_NINE) begin
                        diff = lc - ilds_pkg::CH_ZERO;
                        d    = diff[4:0];
                     end else if (st.base == ilds_pkg::BASE_HEX &&
                                  lc >= ilds_pkg::CH_LOWER_A &&
                                  lc <= ilds_pkg::CH_LOWER_F) begin
                        diff = lc - ilds_pkg::HEX_OFFSET;
                        d    = diff[4:0];
                     end
                     if (d < ilds_pkg::radix_of(st.base)) begin
                        strobe = 1'b1;
                        value  = d[3:0];
                     end else begin
                        st.err = 1'b1;
                     end
                  end
               end
            end
         endcase
      end

      result.digit_value  = value;
      result.digit_strobe = strobe;
      result.base         = st.base;
      result.negative     = st.neg;
      result.error        = st.err;
      result.finished     = last;

      if (last) begin
         st.phase = ilds_pkg::PH_START;
      end
      state_next = st;
   end

endmodule

FILE: rtl/core/integer_literal_digit_scanner.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    ch, first, last
// rsp       out        rsp_valid/rsp_ready    digit_value, digit_strobe, base_code,
//                                             negative, error, finished
//
// One character per cycle sustained while rsp_ready stays high; each transaction yields one result.
// A character passes the input register, then the result register; the scan
// state updates as a character moves from the input to the result register.
// Synchronous active-high reset empties both registers and clears the scan state.
// A stalled rsp holds its result; the input register still takes one more
// character, and req_ready drops only when both registers are full.
module integer_literal_digit_scanner (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_first,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_digit_value,
   output logic       rsp_digit_strobe,
   output logic [2:0] rsp_base_code,
   output logic       rsp_negative,
   output logic       rsp_error,
   output logic       rsp_finished
);

   logic                 in_valid_ff;
   logic [7:0]           in_ch_ff;
   logic                 in_first_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff;
   ilds_pkg::result_type out_ff;
   ilds_pkg::result_type out_in;
   ilds_pkg::state_type  state_ff;
   ilds_pkg::state_type  state_in;
   logic                 out_load;
   logic                 advance;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_load;
   assign req_ready = !in_valid_ff || out_load;

   ilds_step u_step (
      .state_cur  (state_ff),
      .ch         (in_ch_ff),
      .first      (in_first_ff),
      .last       (in_last_ff),
      .state_next (state_in),
      .result     (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ilds_pkg::STATE_CLEAR;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff    <= req_ch;
         in_first_ff <= req_first;
         in_last_ff  <= req_last;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_digit_value  = out_ff.digit_value;
   assign rsp_digit_strobe = out_ff.digit_strobe;
   assign rsp_base_code    = out_ff.base;
   assign rsp_negative     = out_ff.negative;
   assign rsp_error        = out_ff.error;
   assign rsp_finished     = out_ff.finished;

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.phase == ilds_pkg::PH_START)
      else $error("scan state not back at start after final character");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid && rsp_finished == $past(in_last_ff))
      else $error("result register missed an advancing transaction");

   a_strobe_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digit_strobe |->
         !rsp_error && rsp_base_code != ilds_pkg::BASE_INVALID)
      else $error("digit produced on a malformed literal");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_digit_strobe |-> rsp_digit_value == 4'd0)
      else $error("digit value nonzero without strobe");

endmodule
